### rtl/neighbor_table_with_dead_timer_core_assert.svh
// assertion macros for the neighbor table checker
// expects signals named clk and rst in the scope of use
`ifndef NEIGHBOR_TABLE_WITH_DEAD_TIMER_CORE_ASSERT_SVH
`define NEIGHBOR_TABLE_WITH_DEAD_TIMER_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define NTDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define NTDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ntdt_pkg.sv
// shared types and constants of the neighbor table with dead timer
// no dependencies
package ntdt_pkg;

  localparam int IFACE_W    = 2;
  localparam int WORD_W     = 32;
  localparam int LIFE_W     = 8;
  localparam int KIND_W     = 3;
  localparam int CNT_OUT_W  = 5;

  localparam logic [LIFE_W-1:0] HOLD_RESET = 8'd15;

  // result event codes
  localparam logic [KIND_W-1:0] EV_REFRESH = 3'd0;
  localparam logic [KIND_W-1:0] EV_ADDED   = 3'd1;
  localparam logic [KIND_W-1:0] EV_DROPPED = 3'd2;
  localparam logic [KIND_W-1:0] EV_EXPIRED = 3'd3;
  localparam logic [KIND_W-1:0] EV_DONE    = 3'd4;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_HELLO,
    CMD_BAD,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [IFACE_W-1:0]  iface;
    logic [WORD_W-1:0]   id;
    logic [WORD_W-1:0]   addr;
    logic [WORD_W-1:0]   mask;
  } cmd_t;

  typedef struct packed {
    logic [IFACE_W-1:0]  iface;
    logic [WORD_W-1:0]   id;
    logic [WORD_W-1:0]   addr;
    logic [WORD_W-1:0]   mask;
  } entry_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

endpackage

### rtl/ntdt_front.sv
// front part: accepts items and classifies them into queue commands
// depends on ntdt_pkg
module ntdt_front #(
  parameter int IFACE_COUNT = 4
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [ntdt_pkg::IFACE_W-1:0]  iface_index,
  input  logic [ntdt_pkg::WORD_W-1:0]   neighbor_id,
  input  logic [ntdt_pkg::WORD_W-1:0]   neighbor_addr,
  input  logic [ntdt_pkg::WORD_W-1:0]   neighbor_mask,
  input  ntdt_pkg::queue_status_t       q_status,
  output logic                          push,
  output ntdt_pkg::cmd_t                push_data
);

  logic iface_bad;

  assign iface_bad = 5'(iface_index) >= 5'(IFACE_COUNT);
  assign in_stall  = q_status.full;
  assign push      = in_valid && !q_status.full;

  always_comb begin
    push_data.iface = iface_index;
    push_data.id    = neighbor_id;
    push_data.addr  = neighbor_addr;
    push_data.mask  = neighbor_mask;
    if (operation) begin
      push_data.kind = ntdt_pkg::CMD_TICK;
    end else if (iface_bad) begin
      push_data.kind = ntdt_pkg::CMD_BAD;
    end else begin
      push_data.kind = ntdt_pkg::CMD_HELLO;
    end
  end

endmodule

### rtl/ntdt_queue.sv
// short command queue between front and back
// depends on ntdt_pkg
module ntdt_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ntdt_pkg::cmd_t          push_data,
  input  logic                    pop,
  output ntdt_pkg::cmd_t          pop_data,
  output ntdt_pkg::queue_status_t status
);

  ntdt_pkg::cmd_t                   store [ntdt_pkg::QUEUE_DEPTH];
  logic [ntdt_pkg::QPTR_W-1:0]      wr_ptr;
  logic [ntdt_pkg::QPTR_W-1:0]      rd_ptr;
  logic [ntdt_pkg::QCNT_W-1:0]      fill;
  logic                             do_push;
  logic                             do_pop;

  assign status.full      = fill == ntdt_pkg::QCNT_W'(ntdt_pkg::QUEUE_DEPTH);
  assign status.not_empty = fill != '0;
  assign do_push          = push && !status.full;
  assign do_pop           = pop && status.not_empty;
  assign pop_data         = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + ntdt_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + ntdt_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + ntdt_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - ntdt_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/ntdt_back.sv
// back part: walks the slot table for each tick and each hello on an existing interface, and drives the result register
// depends on ntdt_pkg
module ntdt_back #(
  parameter int TABLE_SLOTS = 16,
  parameter int IFACE_COUNT = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [ntdt_pkg::LIFE_W-1:0]    hold_ticks,
  input  logic                           q_not_empty,
  input  ntdt_pkg::cmd_t                 q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ntdt_pkg::KIND_W-1:0]    event_kind,
  output logic [ntdt_pkg::IFACE_W-1:0]   out_iface,
  output logic [ntdt_pkg::WORD_W-1:0]    out_id,
  output logic [ntdt_pkg::WORD_W-1:0]    out_addr,
  output logic [ntdt_pkg::WORD_W-1:0]    out_mask,
  output logic [ntdt_pkg::CNT_OUT_W-1:0] iface_count,
  output logic                           lsu_request,
  output logic                           last
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int IFC_W = (IFACE_COUNT > 1) ? $clog2(IFACE_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

  function automatic logic [ntdt_pkg::CNT_OUT_W-1:0] cnt_out(input logic [CNT_W-1:0] v);
    logic [CNT_W+ntdt_pkg::CNT_OUT_W-1:0] w;
    w = (CNT_W + ntdt_pkg::CNT_OUT_W)'(v);
    return w[ntdt_pkg::CNT_OUT_W-1:0];
  endfunction

  state_t                       state;
  ntdt_pkg::cmd_t               cmd;
  logic [IDX_W-1:0]             cur;
  logic                         hit;
  logic                         free_found;
  logic [IDX_W-1:0]             free_slot;
  logic [TABLE_SLOTS-1:0]       valid;
  logic [CNT_W-1:0]             cnt [IFACE_COUNT];

  // slot memories
  ntdt_pkg::entry_t             ent_mem  [TABLE_SLOTS];
  logic [ntdt_pkg::LIFE_W-1:0]  life_mem [TABLE_SLOTS];
  ntdt_pkg::entry_t             ent_rd;
  logic [ntdt_pkg::LIFE_W-1:0]  life_rd;

  logic                         can_load;
  logic                         last_slot;
  logic                         slot_on;
  logic                         id_hit;
  logic                         expire;
  logic                         step;
  logic [IDX_W-1:0]             rd_addr;
  logic                         ent_we;
  logic                         life_we;
  logic [IDX_W-1:0]             life_wa;
  logic [ntdt_pkg::LIFE_W-1:0]  life_wd;
  logic [IFC_W+1:0]             cmd_ifc_w;
  logic [IFC_W+1:0]             rd_ifc_w;
  logic [IFC_W-1:0]             cidx;
  logic [CNT_W-1:0]             cval;
  logic [CNT_W-1:0]             cval_inc;
  logic [CNT_W-1:0]             cval_dec;

  assign can_load  = !out_valid || !out_stall;
  assign last_slot = cur == IDX_W'(TABLE_SLOTS - 1);
  assign slot_on   = valid[cur];
  assign id_hit    = slot_on && (ent_rd.iface == cmd.iface) && (ent_rd.id == cmd.id);
  assign expire    = slot_on && (life_rd <= ntdt_pkg::LIFE_W'(1));
  assign q_pop     = (state == ST_IDLE) && q_not_empty;

  assign cmd_ifc_w = (IFC_W + 2)'(cmd.iface);
  assign rd_ifc_w  = (IFC_W + 2)'(ent_rd.iface);
  assign cidx      = (state == ST_SCAN) ? rd_ifc_w[IFC_W-1:0] : cmd_ifc_w[IFC_W-1:0];
  assign cval      = cnt[cidx];
  assign cval_inc  = cval + CNT_W'(1);
  assign cval_dec  = cval - CNT_W'(1);

  // a tick holds on a slot that expires while the result register is busy
  assign step = (cmd.kind == ntdt_pkg::CMD_TICK) ? !(expire && !can_load) : !id_hit;

  always_comb begin
    rd_addr = cur;
    if (state == ST_IDLE) begin
      rd_addr = '0;
    end else if (state == ST_SCAN && step && !last_slot) begin
      rd_addr = cur + IDX_W'(1);
    end
  end

  always_comb begin
    ent_we  = 1'b0;
    life_we = 1'b0;
    life_wa = cur;
    life_wd = hold_ticks;
    if (state == ST_SCAN && cmd.kind == ntdt_pkg::CMD_TICK && slot_on && !expire) begin
      life_we = 1'b1;
      life_wd = life_rd - ntdt_pkg::LIFE_W'(1);
    end else if (state == ST_FINISH && can_load && cmd.kind == ntdt_pkg::CMD_HELLO) begin
      if (hit) begin
        life_we = 1'b1;
      end else if (free_found) begin
        ent_we  = 1'b1;
        life_we = 1'b1;
        life_wa = free_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[free_slot] <= '{iface: cmd.iface, id: cmd.id, addr: cmd.addr, mask: cmd.mask};
    end
    ent_rd <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (life_we) begin
      life_mem[life_wa] <= life_wd;
    end
    life_rd <= life_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < IFACE_COUNT; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_not_empty) begin
            cmd        <= q_data;
            cur        <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= (q_data.kind == ntdt_pkg::CMD_BAD) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cmd.kind == ntdt_pkg::CMD_TICK) begin
            if (step) begin
              if (expire) begin
                valid[cur]  <= 1'b0;
                cnt[cidx]   <= cval_dec;
                out_valid   <= 1'b1;
                event_kind  <= ntdt_pkg::EV_EXPIRED;
                out_iface   <= ent_rd.iface;
                out_id      <= ent_rd.id;
                out_addr    <= ent_rd.addr;
                out_mask    <= ent_rd.mask;
                iface_count <= cnt_out(cval_dec);
                lsu_request <= 1'b1;
                last        <= 1'b0;
              end
              if (last_slot) begin
                state <= ST_DONE;
              end else begin
                cur <= cur + IDX_W'(1);
              end
            end
          end else begin
            if (!slot_on && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= cur;
            end
            if (id_hit) begin
              hit   <= 1'b1;
              state <= ST_FINISH;
            end else if (last_slot) begin
              state <= ST_FINISH;
            end else begin
              cur <= cur + IDX_W'(1);
            end
          end
        end
        ST_FINISH: begin
          if (can_load) begin
            out_valid   <= 1'b1;
            out_iface   <= cmd.iface;
            out_id      <= cmd.id;
            out_addr    <= cmd.addr;
            out_mask    <= cmd.mask;
            lsu_request <= 1'b0;
            last        <= 1'b1;
            if (cmd.kind == ntdt_pkg::CMD_BAD) begin
              event_kind  <= ntdt_pkg::EV_DROPPED;
              iface_count <= '0;
            end else if (hit) begin
              // stored address and mask are kept on refresh
              event_kind  <= ntdt_pkg::EV_REFRESH;
              out_addr    <= ent_rd.addr;
              out_mask    <= ent_rd.mask;
              iface_count <= cnt_out(cval);
            end else if (free_found) begin
              valid[free_slot] <= 1'b1;
              cnt[cidx]        <= cval_inc;
              event_kind       <= ntdt_pkg::EV_ADDED;
              iface_count      <= cnt_out(cval_inc);
            end else begin
              event_kind  <= ntdt_pkg::EV_DROPPED;
              iface_count <= cnt_out(cval);
            end
            state <= ST_IDLE;
          end
        end
        ST_DONE: begin
          if (can_load) begin
            out_valid   <= 1'b1;
            event_kind  <= ntdt_pkg::EV_DONE;
            out_iface   <= '0;
            out_id      <= '0;
            out_addr    <= '0;
            out_mask    <= '0;
            iface_count <= '0;
            lsu_request <= 1'b0;
            last        <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/neighbor_table_with_dead_timer_core.sv
// neighbor table with dead timer: top level, joins front, queue and back (ntdt_pkg)
// a hello walks slots until it hits its id or passes the last slot, a tick walks every slot,
//   and a hello on a nonexistent interface skips the walk and goes straight to its result
// one slot a cycle through the single read port of the table memories, unless a tick is
//   held on an expiring slot by a busy result register; the back takes one item at a time
// reset: clears valid bits, counts, queue and out_valid, hold_ticks to 15, no clearing pass
module neighbor_table_with_dead_timer_core #(
  parameter int TABLE_SLOTS = 16,
  parameter int IFACE_COUNT = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  // hold_ticks register write
  input  logic                           cfg_wr_en,
  input  logic [ntdt_pkg::LIFE_W-1:0]    cfg_wr_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic [ntdt_pkg::IFACE_W-1:0]   iface_index,
  input  logic [ntdt_pkg::WORD_W-1:0]    neighbor_id,
  input  logic [ntdt_pkg::WORD_W-1:0]    neighbor_addr,
  input  logic [ntdt_pkg::WORD_W-1:0]    neighbor_mask,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ntdt_pkg::KIND_W-1:0]    event_kind,
  output logic [ntdt_pkg::IFACE_W-1:0]   out_iface,
  output logic [ntdt_pkg::WORD_W-1:0]    out_id,
  output logic [ntdt_pkg::WORD_W-1:0]    out_addr,
  output logic [ntdt_pkg::WORD_W-1:0]    out_mask,
  output logic [ntdt_pkg::CNT_OUT_W-1:0] iface_count,
  output logic                           lsu_request,
  output logic                           last
);

  // lifetime handed to a neighbor on every hello that adds or refreshes it
  logic [ntdt_pkg::LIFE_W-1:0] hold_ticks;

  // front to queue
  logic                        push;
  ntdt_pkg::cmd_t              push_data;
  ntdt_pkg::queue_status_t     q_status;

  // queue to back
  logic                        q_pop;
  ntdt_pkg::cmd_t              q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= ntdt_pkg::HOLD_RESET;
    end else if (cfg_wr_en) begin
      hold_ticks <= cfg_wr_data;
    end
  end

  // classify each transfer: hello, hello on a nonexistent interface, or tick
  ntdt_front #(
    .IFACE_COUNT (IFACE_COUNT)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .iface_index   (iface_index),
    .neighbor_id   (neighbor_id),
    .neighbor_addr (neighbor_addr),
    .neighbor_mask (neighbor_mask),
    .q_status      (q_status),
    .push          (push),
    .push_data     (push_data)
  );

  // two-entry queue so the input keeps taking items while a walk is running, until it is full
  ntdt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .status    (q_status)
  );

  // slot walk: lookup and insert for hellos, lifetime countdown for ticks
  ntdt_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .IFACE_COUNT (IFACE_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .hold_ticks  (hold_ticks),
    .q_not_empty (q_status.not_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_kind  (event_kind),
    .out_iface   (out_iface),
    .out_id      (out_id),
    .out_addr    (out_addr),
    .out_mask    (out_mask),
    .iface_count (iface_count),
    .lsu_request (lsu_request),
    .last        (last)
  );

endmodule

### rtl/ntdt_checker.sv
// port-level checks for the neighbor table, bound to the top level
// depends on ntdt_pkg and neighbor_table_with_dead_timer_core_assert.svh
`include "neighbor_table_with_dead_timer_core_assert.svh"

module ntdt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ntdt_pkg::KIND_W-1:0]    event_kind,
  input logic [ntdt_pkg::WORD_W-1:0]    out_id,
  input logic [ntdt_pkg::CNT_OUT_W-1:0] iface_count,
  input logic                           lsu_request,
  input logic                           last
);

  logic is_hello_ev;

  assign is_hello_ev = (event_kind == ntdt_pkg::EV_REFRESH) ||
                       (event_kind == ntdt_pkg::EV_ADDED) ||
                       (event_kind == ntdt_pkg::EV_DROPPED);

  `NTDT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_kind) && $stable(out_id) && $stable(last), "result changed while stalled")

  `NTDT_ASSERT_NOW(a_expiry_flags, out_valid && event_kind == ntdt_pkg::EV_EXPIRED, lsu_request && !last, "expiry must request lsu and not close the tick")

  `NTDT_ASSERT_NOW(a_done_clean, out_valid && event_kind == ntdt_pkg::EV_DONE, last && !lsu_request && iface_count == '0 && out_id == '0, "tick done result malformed")

  `NTDT_ASSERT_NOW(a_hello_single, out_valid && is_hello_ev, last && !lsu_request, "hello result must be single and final")

endmodule

bind neighbor_table_with_dead_timer_core ntdt_checker u_ntdt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .event_kind  (event_kind),
  .out_id      (out_id),
  .iface_count (iface_count),
  .lsu_request (lsu_request),
  .last        (last)
);

### sim/neighbor_table_with_dead_timer_core_tb.sv
// testbench for the neighbor table with dead timer: hellos and ticks in, table events out
// depends on ntdt_pkg and neighbor_table_with_dead_timer_core; checks every event against
// its own table predictor under random valid/stall idling on both channels
`timescale 1ns / 100ps

module neighbor_table_with_dead_timer_core_tb;

  localparam int IFACE_W   = ntdt_pkg::IFACE_W;
  localparam int WORD_W    = ntdt_pkg::WORD_W;
  localparam int LIFE_W    = ntdt_pkg::LIFE_W;
  localparam int KIND_W    = ntdt_pkg::KIND_W;
  localparam int CNT_OUT_W = ntdt_pkg::CNT_OUT_W;

  localparam int SLOTS  = 16;
  localparam int IFACES = 4;

  // item operation codes
  localparam logic OP_HELLO = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // how long the receiver holds off once to back the block up
  localparam int LONG_HOLD_CYCLES = 600;

  typedef struct packed {
    logic               op;
    logic [IFACE_W-1:0] iface;
    logic [WORD_W-1:0]  id;
    logic [WORD_W-1:0]  addr;
    logic [WORD_W-1:0]  mask;
  } nbr_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [IFACE_W-1:0]   iface;
    logic [WORD_W-1:0]    id;
    logic [WORD_W-1:0]    addr;
    logic [WORD_W-1:0]    mask;
    logic [CNT_OUT_W-1:0] count;
    logic                 lsu;
    logic                 last;
  } nbr_result_t;

  // clock, reset, config port
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [LIFE_W-1:0]    cfg_wr_data = '0;

  // input channel
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  nbr_item_t            cur_item = '0;
  logic                 operation;
  logic [IFACE_W-1:0]   iface_index;
  logic [WORD_W-1:0]    neighbor_id;
  logic [WORD_W-1:0]    neighbor_addr;
  logic [WORD_W-1:0]    neighbor_mask;

  // result channel
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [KIND_W-1:0]    event_kind;
  logic [IFACE_W-1:0]   out_iface;
  logic [WORD_W-1:0]    out_id;
  logic [WORD_W-1:0]    out_addr;
  logic [WORD_W-1:0]    out_mask;
  logic [CNT_OUT_W-1:0] iface_count;
  logic                 lsu_request;
  logic                 last;

  // items waiting for the driver and events waiting for the block
  nbr_item_t            offered_items[$];
  nbr_result_t          pending_events[$];

  // predictor copy of the table and the hold register
  logic                 nb_valid [SLOTS];
  logic [IFACE_W-1:0]   nb_iface [SLOTS];
  logic [WORD_W-1:0]    nb_id    [SLOTS];
  logic [WORD_W-1:0]    nb_addr  [SLOTS];
  logic [WORD_W-1:0]    nb_mask  [SLOTS];
  logic [LIFE_W-1:0]    nb_life  [SLOTS];
  logic [CNT_OUT_W-1:0] nb_count [IFACES];
  logic [LIFE_W-1:0]    nb_hold = ntdt_pkg::HOLD_RESET;

  // idling controls; the gap limits are changed between phases only
  int                   send_gap_max = 11;
  int                   recv_gap_max = 11;
  int                   send_wait = 0;
  int                   recv_wait = 0;
  logic                 hold_req = 1'b0;
  logic                 hold_fired = 1'b0;
  int                   hold_left = 0;
  int                   fail_count = 0;

  assign operation     = cur_item.op;
  assign iface_index   = cur_item.iface;
  assign neighbor_id   = cur_item.id;
  assign neighbor_addr = cur_item.addr;
  assign neighbor_mask = cur_item.mask;

  neighbor_table_with_dead_timer_core #(
    .TABLE_SLOTS(SLOTS),
    .IFACE_COUNT(IFACES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .iface_index  (iface_index),
    .neighbor_id  (neighbor_id),
    .neighbor_addr(neighbor_addr),
    .neighbor_mask(neighbor_mask),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .out_iface    (out_iface),
    .out_id       (out_id),
    .out_addr     (out_addr),
    .out_mask     (out_mask),
    .iface_count  (iface_count),
    .lsu_request  (lsu_request),
    .last         (last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // apply one accepted item to the predicted table and queue the events it causes
  function automatic void table_apply(nbr_item_t it);
    nbr_result_t ev;
    int          free_slot;
    logic        hit;
    free_slot = -1;
    hit = 1'b0;
    ev = '0;
    if (it.op == OP_TICK) begin
      // walk slots in ascending order, a lifetime of 0 or 1 dies now
      for (int s = 0; s < SLOTS; s++) begin
        if (nb_valid[s]) begin
          if (nb_life[s] > 1) begin
            nb_life[s] = nb_life[s] - 1'b1;
          end else begin
            nb_life[s] = '0;
            nb_valid[s] = 1'b0;
            if (nb_count[nb_iface[s]] > 0) nb_count[nb_iface[s]] = nb_count[nb_iface[s]] - 1'b1;
            ev.kind  = ntdt_pkg::EV_EXPIRED;
            ev.iface = nb_iface[s];
            ev.id    = nb_id[s];
            ev.addr  = nb_addr[s];
            ev.mask  = nb_mask[s];
            ev.count = nb_count[nb_iface[s]];
            ev.lsu   = 1'b1;
            ev.last  = 1'b0;
            pending_events.push_back(ev);
          end
        end
      end
      ev = '0;
      ev.kind = ntdt_pkg::EV_DONE;
      ev.last = 1'b1;
      pending_events.push_back(ev);
    end else begin
      ev.iface = it.iface;
      ev.id    = it.id;
      ev.addr  = it.addr;
      ev.mask  = it.mask;
      ev.lsu   = 1'b0;
      ev.last  = 1'b1;
      if (int'(it.iface) >= IFACES) begin
        // interface out of range, cannot happen with four interfaces on two bits
        ev.kind  = ntdt_pkg::EV_DROPPED;
        ev.count = '0;
      end else begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!hit) begin
            if (nb_valid[s]) begin
              if (nb_iface[s] == it.iface && nb_id[s] == it.id) begin
                // refresh keeps the stored address and mask
                hit = 1'b1;
                nb_life[s] = nb_hold;
                ev.kind  = ntdt_pkg::EV_REFRESH;
                ev.addr  = nb_addr[s];
                ev.mask  = nb_mask[s];
                ev.count = nb_count[it.iface];
              end
            end else if (free_slot < 0) begin
              free_slot = s;
            end
          end
        end
        if (!hit) begin
          if (free_slot < 0) begin
            // table full
            ev.kind  = ntdt_pkg::EV_DROPPED;
            ev.count = nb_count[it.iface];
          end else begin
            nb_valid[free_slot] = 1'b1;
            nb_iface[free_slot] = it.iface;
            nb_id[free_slot]    = it.id;
            nb_addr[free_slot]  = it.addr;
            nb_mask[free_slot]  = it.mask;
            nb_life[free_slot]  = nb_hold;
            nb_count[it.iface]  = nb_count[it.iface] + 1'b1;
            ev.kind  = ntdt_pkg::EV_ADDED;
            ev.count = nb_count[it.iface];
          end
        end
      end
      pending_events.push_back(ev);
    end
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                             input logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // driver: offers queued items, draws a gap after every transfer
  always @(posedge clk) begin : driver
    int n;
    if (rst) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else if (in_valid && !in_stall) begin
      table_apply(cur_item);
      n = $urandom_range(send_gap_max, 0);
      if (n == 0 && offered_items.size() > 0) begin
        // back-to-back, valid stays high
        cur_item <= offered_items.pop_front();
      end else begin
        in_valid  <= 1'b0;
        send_wait <= (n > 0) ? n - 1 : 0;
      end
    end else if (!in_valid) begin
      if (send_wait > 0) begin
        send_wait <= send_wait - 1;
      end else if (offered_items.size() > 0) begin
        cur_item <= offered_items.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // one long receiver hold-off, counted on its own
  always @(posedge clk) begin : long_hold
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req && !hold_fired) begin
      hold_left  <= LONG_HOLD_CYCLES;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each result transfer against the oldest expectation, drives stall
  always @(posedge clk) begin : monitor
    nbr_result_t exp_r;
    int          n;
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $error("unexpected result: kind %0d id %0h", event_kind, out_id);
          fail_count++;
        end else begin
          exp_r = pending_events.pop_front();
          check_field("event_kind", WORD_W'(exp_r.kind), WORD_W'(event_kind));
          check_field("out_iface", WORD_W'(exp_r.iface), WORD_W'(out_iface));
          check_field("out_id", exp_r.id, out_id);
          check_field("out_addr", exp_r.addr, out_addr);
          check_field("out_mask", exp_r.mask, out_mask);
          check_field("iface_count", WORD_W'(exp_r.count), WORD_W'(iface_count));
          check_field("lsu_request", WORD_W'(exp_r.lsu), WORD_W'(lsu_request));
          check_field("last", WORD_W'(exp_r.last), WORD_W'(last));
        end
        n = $urandom_range(recv_gap_max, 0);
        recv_wait <= (n > 0) ? n - 1 : 0;
        out_stall <= (n > 0) || (hold_left != 0);
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (hold_left != 0);
      end
    end
  end

  task automatic push_hello(input logic [IFACE_W-1:0] ifc, input logic [WORD_W-1:0] id,
                            input logic [WORD_W-1:0] addr, input logic [WORD_W-1:0] mask);
    nbr_item_t it;
    it.op    = OP_HELLO;
    it.iface = ifc;
    it.id    = id;
    it.addr  = addr;
    it.mask  = mask;
    offered_items.push_back(it);
  endtask

  // tick fields are ignored by the block, fill them with noise anyway
  task automatic push_tick();
    nbr_item_t it;
    it.op    = OP_TICK;
    it.iface = IFACE_W'($urandom_range(3, 0));
    it.id    = $urandom;
    it.addr  = $urandom;
    it.mask  = $urandom;
    offered_items.push_back(it);
  endtask

  // write hold_ticks while idle, then set the idling of the next phase
  task automatic start_phase(input logic [LIFE_W-1:0] hold, input int sgap, input int rgap);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hold;
    nb_hold = hold;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    send_gap_max = sgap;
    recv_gap_max = rgap;
  endtask

  // mostly hellos from a small pool of neighbors so that refreshes and expiries happen
  task automatic add_random_items(input int count, input int pool_n, input int tick_pct);
    logic [WORD_W-1:0]  pool_id [32];
    logic [IFACE_W-1:0] pool_if [32];
    int                 k;
    int                 r;
    for (int i = 0; i < pool_n; i++) begin
      pool_id[i] = $urandom;
      pool_if[i] = IFACE_W'($urandom_range(3, 0));
    end
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99, 0) < tick_pct) begin
        push_tick();
      end else begin
        r = $urandom_range(99, 0);
        k = $urandom_range(pool_n - 1, 0);
        if (r < 10) begin
          // stray neighbor
          push_hello(IFACE_W'($urandom_range(3, 0)), $urandom, $urandom, $urandom);
        end else if (r < 18) begin
          // known id on some other interface
          push_hello(IFACE_W'($urandom_range(3, 0)), pool_id[k], $urandom, $urandom);
        end else begin
          push_hello(pool_if[k], pool_id[k], $urandom, $urandom);
        end
      end
    end
  endtask

  // idle means every item transferred and every event seen, then let the walk finish
  task automatic wait_idle();
    while (offered_items.size() != 0 || in_valid || pending_events.size() != 0)
      @(negedge clk);
    repeat (SLOTS + 8) @(negedge clk);
  endtask

  initial begin : stimulus
    for (int s = 0; s < SLOTS; s++) begin
      nb_valid[s] = 1'b0;
      nb_iface[s] = '0;
      nb_id[s]    = '0;
      nb_addr[s]  = '0;
      nb_mask[s]  = '0;
      nb_life[s]  = '0;
    end
    for (int i = 0; i < IFACES; i++) nb_count[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, refresh keeping stored fields, same id on another interface,
    // a hello that fills the last free slot, a tick that expires all sixteen, a tick on an empty table
    start_phase(8'd3, 11, 11);
    push_hello(2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_hello(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_hello(2'd0, 32'h0000_0000, 32'h1234_5678, 32'hFFFF_FF00);
    push_hello(2'd1, 32'hFFFF_FFFF, 32'h0A00_0001, 32'hFFFF_0000);
    for (int i = 0; i < SLOTS - 4; i++)
      push_hello(IFACE_W'(i % IFACES), $urandom, $urandom, $urandom);
    push_hello(2'd2, $urandom, $urandom, $urandom);
    repeat (4) push_tick();
    wait_idle();

    // shortest lifetime
    start_phase(8'd1, 11, 11);
    add_random_items(20, 12, 30);
    wait_idle();

    // zero lifetime behaves like one
    start_phase(8'd0, 11, 11);
    add_random_items(15, 10, 35);
    wait_idle();

    // receiver holds off while the sender keeps offering back to back
    start_phase(8'd4, 0, 11);
    hold_req = 1'b1;
    add_random_items(30, 20, 25);
    wait_idle();

    start_phase(LIFE_W'($urandom_range(20, 2)), 11, 11);
    add_random_items(25, 16, 30);
    wait_idle();

    // longest lifetime, no idling, large pool fills the table
    start_phase(8'd255, 0, 0);
    add_random_items(20, 24, 15);
    wait_idle();

    if (fail_count == 0) begin
      $display("** neighbor_table_with_dead_timer_core: PASSED **");
    end else begin
      $display("** neighbor_table_with_dead_timer_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("** neighbor_table_with_dead_timer_core: FAILED **");
    $finish;
  end

endmodule
